// File: hdl/core_request_queue_macros.svh
// Assertion macros for the core request queue checker.
// They expect signals named clk and rst in the scope where they are used.
`ifndef CORE_REQUEST_QUEUE_MACROS_SVH
`define CORE_REQUEST_QUEUE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CRQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("core request queue: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define CRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("core request queue: next-cycle check failed");

// The consequent holds once the delay n has passed after the antecedent.
`define CRQ_ASSERT_LATER(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("core request queue: latency check failed");

`endif

// File: hdl/crq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 8;

  localparam int EP_W    = 16;
  localparam int ACT_W   = 16;
  localparam int PHYS_W  = 48;
  localparam int FAULT_W = 5;
  localparam int RESP_W  = 64;
  localparam int ID_OUT_W = 3;
  localparam int PAY_W   = PHYS_W + 1 + FAULT_W;

  typedef enum logic [1:0] {
    FUNC_FOREIGN  = 2'd0,
    FUNC_PMP      = 2'd1,
    FUNC_COMPLETE = 2'd2,
    FUNC_ABORT    = 2'd3
  } func_t;

  localparam logic [1:0] KIND_IDLE    = 2'd0;
  localparam logic [1:0] KIND_FOREIGN = 2'd1;
  localparam logic [1:0] KIND_PMP     = 2'd2;

  localparam logic ENTRY_FOREIGN = 1'b0;
  localparam logic ENTRY_PMP     = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DISABLED = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_ABSENT   = 3'd4;

  typedef struct packed {
    logic load;
    logic eval;
    logic apply;
    logic report;
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: hdl/core_request_queue.sv
// Channel   Handshake              Beat contents
// command   start / busy           func, endpoint, activity, phys_addr, is_write,
//                                  fault_code, target_id, resp_word
// config    cfg_write              cfg_data (PMP failure enable)
// result    result_strobe          req_*, irq_pulse, new_id, done_*, status
//
// A command beat is taken when start is high and busy is low.
// Its result beat follows the evaluate, update and report steps and is shown for one cycle;
// busy stays high for the three sequencer steps, so no new command is taken until they end.
// A new command may be taken in the cycle its predecessor's result is shown.
// Synchronous reset empties the queue, frees all ids and clears the enable.
// The result side cannot stall; each result beat is lost if not taken at once.
`timescale 1ns / 1ps
`default_nettype none

module core_request_queue #(
  parameter int QUEUE_DEPTH = crq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_write,
  input  logic                          cfg_data,
  input  logic [1:0]                    func,
  input  logic [crq_pkg::EP_W-1:0]      endpoint,
  input  logic [crq_pkg::ACT_W-1:0]     activity,
  input  logic [crq_pkg::PHYS_W-1:0]    phys_addr,
  input  logic                          is_write,
  input  logic [crq_pkg::FAULT_W-1:0]   fault_code,
  input  logic [crq_pkg::ID_OUT_W-1:0]  target_id,
  input  logic [crq_pkg::RESP_W-1:0]    resp_word,
  output logic                          result_strobe,
  output logic [1:0]                    req_kind,
  output logic [crq_pkg::EP_W-1:0]      req_endpoint,
  output logic [crq_pkg::ACT_W-1:0]     req_activity,
  output logic [crq_pkg::PHYS_W-1:0]    req_phys,
  output logic                          req_write,
  output logic [crq_pkg::FAULT_W-1:0]   req_fault,
  output logic                          irq_pulse,
  output logic [crq_pkg::ID_OUT_W-1:0]  new_id,
  output logic                          done_valid,
  output logic [crq_pkg::ID_OUT_W-1:0]  done_id,
  output logic [crq_pkg::RESP_W-1:0]    done_resp,
  output logic [2:0]                    status
);

  crq_pkg::dp_cmd_t cmd;

  crq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  crq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .func          (func),
    .endpoint      (endpoint),
    .activity      (activity),
    .phys_addr     (phys_addr),
    .is_write      (is_write),
    .fault_code    (fault_code),
    .target_id     (target_id),
    .resp_word     (resp_word),
    .result_strobe (result_strobe),
    .req_kind      (req_kind),
    .req_endpoint  (req_endpoint),
    .req_activity  (req_activity),
    .req_phys      (req_phys),
    .req_write     (req_write),
    .req_fault     (req_fault),
    .irq_pulse     (irq_pulse),
    .new_id        (new_id),
    .done_valid    (done_valid),
    .done_id       (done_id),
    .done_resp     (done_resp),
    .status        (status)
  );

endmodule

`default_nettype wire

// File: hdl/crq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module crq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output crq_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_APPLY  = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// File: hdl/crq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module crq_datapath #(
  parameter int QUEUE_DEPTH = crq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  crq_pkg::dp_cmd_t              cmd,
  input  logic                          cfg_write,
  input  logic                          cfg_data,
  input  logic [1:0]                    func,
  input  logic [crq_pkg::EP_W-1:0]      endpoint,
  input  logic [crq_pkg::ACT_W-1:0]     activity,
  input  logic [crq_pkg::PHYS_W-1:0]    phys_addr,
  input  logic                          is_write,
  input  logic [crq_pkg::FAULT_W-1:0]   fault_code,
  input  logic [crq_pkg::ID_OUT_W-1:0]  target_id,
  input  logic [crq_pkg::RESP_W-1:0]    resp_word,
  output logic                          result_strobe,
  output logic [1:0]                    req_kind,
  output logic [crq_pkg::EP_W-1:0]      req_endpoint,
  output logic [crq_pkg::ACT_W-1:0]     req_activity,
  output logic [crq_pkg::PHYS_W-1:0]    req_phys,
  output logic                          req_write,
  output logic [crq_pkg::FAULT_W-1:0]   req_fault,
  output logic                          irq_pulse,
  output logic [crq_pkg::ID_OUT_W-1:0]  new_id,
  output logic                          done_valid,
  output logic [crq_pkg::ID_OUT_W-1:0]  done_id,
  output logic [crq_pkg::RESP_W-1:0]    done_resp,
  output logic [2:0]                    status
);

  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = PW + crq_pkg::ID_OUT_W;
  localparam int PAD = crq_pkg::PAY_W - crq_pkg::EP_W - crq_pkg::ACT_W;

  logic                        pmp_enable;

  logic                        ent_kind [QUEUE_DEPTH];
  logic [crq_pkg::PAY_W-1:0]   ent_pay  [QUEUE_DEPTH];
  logic [PW-1:0]               ent_id   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      occ;
  logic [QUEUE_DEPTH-1:0]      occ_next;
  logic [QUEUE_DEPTH-1:0]      used;
  logic [QUEUE_DEPTH-1:0]      used_next;

  crq_pkg::func_t              c_func;
  logic [crq_pkg::EP_W-1:0]    c_endpoint;
  logic [crq_pkg::ACT_W-1:0]   c_activity;
  logic [crq_pkg::PHYS_W-1:0]  c_phys;
  logic                        c_write;
  logic [crq_pkg::FAULT_W-1:0] c_fault;
  logic [crq_pkg::ID_OUT_W-1:0] c_tid;
  logic [crq_pkg::RESP_W-1:0]  c_resp;

  logic [2:0]                  e_status;
  logic                        e_enq;
  logic                        e_rm;
  logic                        e_cpl;
  logic                        e_irq_sel;
  logic [PW-1:0]               e_free_id;
  logic [PW-1:0]               e_pos;
  logic [PW-1:0]               e_clr_id;
  logic [PW-1:0]               e_done_id;

  logic [CW-1:0]               tid_ext;
  logic [QUEUE_DEPTH-1:0]      match;
  logic                        found;
  logic [PW-1:0]               match_pos;
  logic [PW-1:0]               free_id;
  logic                        full;
  logic                        head_valid;
  logic [2:0]                  status_eval;
  logic                        enq_eval;
  logic                        rm_eval;
  logic                        cpl_eval;
  logic                        irq_sel_eval;

  logic                        new_kind;
  logic [crq_pkg::PAY_W-1:0]   new_pay;
  logic [CW-1:0]               free_ext;
  logic [CW-1:0]               done_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      pmp_enable <= 1'b0;
    end else if (cfg_write) begin
      pmp_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_func     <= crq_pkg::func_t'(func);
      c_endpoint <= endpoint;
      c_activity <= activity;
      c_phys     <= phys_addr;
      c_write    <= is_write;
      c_fault    <= fault_code;
      c_tid      <= target_id;
      c_resp     <= resp_word;
    end
  end

  assign full       = occ[QUEUE_DEPTH-1];
  assign head_valid = occ[0];
  assign tid_ext    = {{PW{1'b0}}, c_tid};

  always_comb begin
    match     = '0;
    match_pos = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = occ[i] && ({{crq_pkg::ID_OUT_W{1'b0}}, ent_id[i]} == tid_ext);
      if (match[i]) begin
        match_pos = match_pos | PW'(i);
      end
    end
  end

  assign found = |match;

  always_comb begin
    free_id = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_id = PW'(i);
      end
    end
  end

  always_comb begin
    status_eval  = crq_pkg::ST_OK;
    enq_eval     = 1'b0;
    rm_eval      = 1'b0;
    cpl_eval     = 1'b0;
    irq_sel_eval = 1'b0;
    unique case (c_func)
      crq_pkg::FUNC_FOREIGN, crq_pkg::FUNC_PMP: begin
        if ((c_func == crq_pkg::FUNC_PMP) && !pmp_enable) begin
          status_eval = crq_pkg::ST_DISABLED;
        end else if (full) begin
          status_eval = crq_pkg::ST_FULL;
        end else begin
          enq_eval     = 1'b1;
          irq_sel_eval = !head_valid;
        end
      end
      crq_pkg::FUNC_COMPLETE: begin
        if (!head_valid) begin
          status_eval = crq_pkg::ST_EMPTY;
        end else begin
          rm_eval      = 1'b1;
          cpl_eval     = 1'b1;
          irq_sel_eval = 1'b1;
        end
      end
      crq_pkg::FUNC_ABORT: begin
        irq_sel_eval = 1'b1;
        if (found) begin
          rm_eval = 1'b1;
        end else begin
          status_eval = crq_pkg::ST_ABSENT;
        end
      end
      default: begin
        status_eval = crq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      e_status  <= status_eval;
      e_enq     <= enq_eval;
      e_rm      <= rm_eval;
      e_cpl     <= cpl_eval;
      e_irq_sel <= irq_sel_eval;
      e_free_id <= free_id;
      e_done_id <= ent_id[0];
      if (c_func == crq_pkg::FUNC_COMPLETE) begin
        e_pos    <= '0;
        e_clr_id <= ent_id[0];
      end else begin
        e_pos    <= match_pos;
        e_clr_id <= tid_ext[PW-1:0];
      end
    end
  end

  assign new_kind = (c_func == crq_pkg::FUNC_PMP) ? crq_pkg::ENTRY_PMP : crq_pkg::ENTRY_FOREIGN;
  assign new_pay  = (c_func == crq_pkg::FUNC_PMP) ? {c_fault, c_write, c_phys}
                                                  : {{PAD{1'b0}}, c_activity, c_endpoint};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_ent
    logic prev_occ;
    logic wr_en;

    if (i == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_rest
      assign prev_occ = occ[i-1];
    end

    assign wr_en = cmd.apply && e_enq && !occ[i] && prev_occ;

    if (i < QUEUE_DEPTH - 1) begin : g_shift
      logic sh_en;
      assign sh_en = cmd.apply && e_rm && (PW'(i) >= e_pos);

      always_ff @(posedge clk) begin
        if (wr_en) begin
          ent_kind[i] <= new_kind;
          ent_pay[i]  <= new_pay;
          ent_id[i]   <= e_free_id;
        end else if (sh_en) begin
          ent_kind[i] <= ent_kind[i+1];
          ent_pay[i]  <= ent_pay[i+1];
          ent_id[i]   <= ent_id[i+1];
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (wr_en) begin
          ent_kind[i] <= new_kind;
          ent_pay[i]  <= new_pay;
          ent_id[i]   <= e_free_id;
        end
      end
    end
  end

  always_comb begin
    occ_next  = occ;
    used_next = used;
    if (cmd.apply && e_enq) begin
      occ_next = (occ << 1) | QUEUE_DEPTH'(1);
    end else if (cmd.apply && e_rm) begin
      occ_next = occ >> 1;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.apply && e_enq && (PW'(i) == e_free_id)) begin
        used_next[i] = 1'b1;
      end
      if (cmd.apply && e_rm && (PW'(i) == e_clr_id)) begin
        used_next[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      used <= '0;
    end else begin
      occ  <= occ_next;
      used <= used_next;
    end
  end

  assign free_ext = {{crq_pkg::ID_OUT_W{1'b0}}, e_free_id};
  assign done_ext = {{crq_pkg::ID_OUT_W{1'b0}}, e_done_id};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      req_kind     <= crq_pkg::KIND_IDLE;
      req_endpoint <= '0;
      req_activity <= '0;
      req_phys     <= '0;
      req_write    <= 1'b0;
      req_fault    <= '0;
      if (occ[0]) begin
        if (ent_kind[0] == crq_pkg::ENTRY_PMP) begin
          req_kind  <= crq_pkg::KIND_PMP;
          req_phys  <= ent_pay[0][crq_pkg::PHYS_W-1:0];
          req_write <= ent_pay[0][crq_pkg::PHYS_W];
          req_fault <= ent_pay[0][crq_pkg::PAY_W-1:crq_pkg::PHYS_W+1];
        end else begin
          req_kind     <= crq_pkg::KIND_FOREIGN;
          req_endpoint <= ent_pay[0][crq_pkg::EP_W-1:0];
          req_activity <= ent_pay[0][crq_pkg::EP_W+crq_pkg::ACT_W-1:crq_pkg::EP_W];
        end
      end
      irq_pulse  <= e_irq_sel && occ[0];
      new_id     <= e_enq ? free_ext[crq_pkg::ID_OUT_W-1:0] : '0;
      done_valid <= e_cpl;
      done_id    <= e_cpl ? done_ext[crq_pkg::ID_OUT_W-1:0] : '0;
      done_resp  <= e_cpl ? c_resp : '0;
      status     <= e_status;
    end
  end

endmodule

`default_nettype wire

// File: hdl/crq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "core_request_queue_macros.svh"

module crq_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_strobe,
  input logic       irq_pulse,
  input logic       done_valid,
  input logic [1:0] req_kind,
  input logic [2:0] status
);

  `CRQ_ASSERT_SAME(a_strobe_when_free, result_strobe, !busy)
  `CRQ_ASSERT_LATER(a_result_latency, start && !busy, 4, result_strobe)
  `CRQ_ASSERT_SAME(a_irq_shows_request, result_strobe && irq_pulse, req_kind != crq_pkg::KIND_IDLE)
  `CRQ_ASSERT_SAME(a_done_is_ok, result_strobe && done_valid, status == crq_pkg::ST_OK)

endmodule

bind core_request_queue crq_checker u_crq_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .irq_pulse     (irq_pulse),
  .done_valid    (done_valid),
  .req_kind      (req_kind),
  .status        (status)
);

`default_nettype wire

// File: verif/core_request_queue_tb.sv
`timescale 1ns / 1ps

module core_request_queue_tb;
  import crq_pkg::*;

  localparam int QD = DEFAULT_QUEUE_DEPTH;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES = 6;
  localparam int PHASE_BEATS = 147;

  typedef enum logic [1:0] {
    ACT_CMD,
    ACT_CFG,
    ACT_DRAIN,
    ACT_PACE
  } act_kind_t;

  typedef struct packed {
    act_kind_t             what;
    func_t                 op;
    logic [EP_W-1:0]       ep;
    logic [ACT_W-1:0]      act;
    logic [PHYS_W-1:0]     phys;
    logic                  wr;
    logic [FAULT_W-1:0]    fault;
    logic [ID_OUT_W-1:0]   tid;
    logic [RESP_W-1:0]     resp;
    logic                  cfg_value;
    logic [6:0]            pace;
  } beat_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [EP_W-1:0]       ep;
    logic [ACT_W-1:0]      act;
    logic [PHYS_W-1:0]     phys;
    logic                  wr;
    logic [FAULT_W-1:0]    fault;
    logic                  irq;
    logic [ID_OUT_W-1:0]   nid;
    logic                  dvalid;
    logic [ID_OUT_W-1:0]   did;
    logic [RESP_W-1:0]     dresp;
    logic [2:0]            status;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  cfg_write = 1'b0;
  logic                  cfg_data = 1'b0;
  logic [1:0]            func = FUNC_FOREIGN;
  logic [EP_W-1:0]       endpoint = '0;
  logic [ACT_W-1:0]      activity = '0;
  logic [PHYS_W-1:0]     phys_addr = '0;
  logic                  is_write = 1'b0;
  logic [FAULT_W-1:0]    fault_code = '0;
  logic [ID_OUT_W-1:0]   target_id = '0;
  logic [RESP_W-1:0]     resp_word = '0;
  logic                  result_strobe;
  logic [1:0]            req_kind;
  logic [EP_W-1:0]       req_endpoint;
  logic [ACT_W-1:0]      req_activity;
  logic [PHYS_W-1:0]     req_phys;
  logic                  req_write;
  logic [FAULT_W-1:0]    req_fault;
  logic                  irq_pulse;
  logic [ID_OUT_W-1:0]   new_id;
  logic                  done_valid;
  logic [ID_OUT_W-1:0]   done_id;
  logic [RESP_W-1:0]     done_resp;
  logic [2:0]            status;

  always #10 clk = ~clk;

  core_request_queue #(
    .QUEUE_DEPTH(QD)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .func(func),
    .endpoint(endpoint),
    .activity(activity),
    .phys_addr(phys_addr),
    .is_write(is_write),
    .fault_code(fault_code),
    .target_id(target_id),
    .resp_word(resp_word),
    .result_strobe(result_strobe),
    .req_kind(req_kind),
    .req_endpoint(req_endpoint),
    .req_activity(req_activity),
    .req_phys(req_phys),
    .req_write(req_write),
    .req_fault(req_fault),
    .irq_pulse(irq_pulse),
    .new_id(new_id),
    .done_valid(done_valid),
    .done_id(done_id),
    .done_resp(done_resp),
    .status(status)
  );

  // Shadow copy of the request queue and the core-request register.
  logic                  slot_pmp     [QD];
  logic [PAY_W-1:0]      slot_payload [QD];
  logic [ID_OUT_W-1:0]   slot_id      [QD];
  logic                  slot_waiting [QD];
  int                    slot_count = 0;
  logic [1:0]            shown_kind = KIND_IDLE;
  logic [EP_W-1:0]       shown_ep = '0;
  logic [ACT_W-1:0]      shown_act = '0;
  logic [PHYS_W-1:0]     shown_phys = '0;
  logic                  shown_wr = 1'b0;
  logic [FAULT_W-1:0]    shown_fault = '0;
  logic                  pmp_on = 1'b0;

  beat_t                 pending[$];
  outcome_t              due_results[$];
  beat_t                 cur_beat;
  int                    issued = 0;
  int                    got = 0;
  int                    fails = 0;
  int                    idle_pct = 0;

  function automatic void add_pending(beat_t b);
    pending.insert(pending.size(), b);
  endfunction

  function automatic beat_t take_pending();
    beat_t b;
    b = pending[0];
    pending.delete(0);
    return b;
  endfunction

  function automatic void show_idle();
    shown_kind = KIND_IDLE;
    shown_ep = '0;
    shown_act = '0;
    shown_phys = '0;
    shown_wr = 1'b0;
    shown_fault = '0;
  endfunction

  function automatic logic launch_head();
    logic [PAY_W-1:0] p;
    if (slot_count == 0) begin
      return 1'b0;
    end
    p = slot_payload[0];
    show_idle();
    if (slot_pmp[0] == ENTRY_FOREIGN) begin
      shown_kind = KIND_FOREIGN;
      shown_ep = p[15:0];
      shown_act = p[31:16];
    end else begin
      shown_kind = KIND_PMP;
      shown_phys = p[47:0];
      shown_wr = p[48];
      shown_fault = p[53:49];
    end
    slot_waiting[0] = 1'b0;
    return 1'b1;
  endfunction

  function automatic void drop_slot(int pos);
    int i;
    for (i = pos; i + 1 < slot_count; i++) begin
      slot_pmp[i] = slot_pmp[i + 1];
      slot_payload[i] = slot_payload[i + 1];
      slot_id[i] = slot_id[i + 1];
      slot_waiting[i] = slot_waiting[i + 1];
    end
    slot_count--;
  endfunction

  function automatic outcome_t queue_step(beat_t b);
    outcome_t o;
    logic hit;
    logic found;
    logic [ID_OUT_W-1:0] free_id;
    int k;
    int j;
    o = '0;
    o.status = ST_OK;
    case (b.op)
      FUNC_FOREIGN, FUNC_PMP: begin
        if (b.op == FUNC_PMP && !pmp_on) begin
          o.status = ST_DISABLED;
        end else if (slot_count >= QD) begin
          o.status = ST_FULL;
        end else begin
          free_id = '0;
          found = 1'b0;
          for (k = 0; k < QD && !found; k++) begin
            hit = 1'b0;
            for (j = 0; j < slot_count; j++) begin
              if (slot_id[j] == k[ID_OUT_W-1:0]) begin
                hit = 1'b1;
              end
            end
            if (!hit) begin
              free_id = k[ID_OUT_W-1:0];
              found = 1'b1;
            end
          end
          if (b.op == FUNC_FOREIGN) begin
            slot_pmp[slot_count] = ENTRY_FOREIGN;
            slot_payload[slot_count] = PAY_W'({b.act, b.ep});
          end else begin
            slot_pmp[slot_count] = ENTRY_PMP;
            slot_payload[slot_count] = {b.fault, b.wr, b.phys};
          end
          slot_id[slot_count] = free_id;
          slot_waiting[slot_count] = 1'b1;
          slot_count++;
          o.nid = free_id;
          if (slot_count == 1) begin
            o.irq = launch_head();
          end
        end
      end
      FUNC_COMPLETE: begin
        if (slot_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.dvalid = 1'b1;
          o.did = slot_id[0];
          o.dresp = b.resp;
          drop_slot(0);
          show_idle();
          o.irq = launch_head();
        end
      end
      default: begin
        hit = 1'b0;
        for (j = 0; j < slot_count && !hit; j++) begin
          if (slot_id[j] == b.tid) begin
            if (!slot_waiting[j]) begin
              show_idle();
            end
            drop_slot(j);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          o.status = ST_ABSENT;
        end
        o.irq = launch_head();
      end
    endcase
    o.kind = shown_kind;
    o.ep = shown_ep;
    o.act = shown_act;
    o.phys = shown_phys;
    o.wr = shown_wr;
    o.fault = shown_fault;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] wanted);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, seen, wanted);
    fails++;
  endtask

  task automatic check_field(string what, logic [63:0] seen, logic [63:0] wanted);
    if (seen !== wanted) begin
      report_mismatch(what, seen, wanted);
    end
  endtask

  function automatic beat_t rand_beat(func_t op);
    beat_t b;
    b = '0;
    b.what = ACT_CMD;
    b.op = op;
    b.ep = EP_W'($urandom);
    b.act = ACT_W'($urandom);
    b.phys = PHYS_W'({$urandom, $urandom});
    b.wr = 1'($urandom);
    b.fault = FAULT_W'($urandom);
    b.tid = ID_OUT_W'($urandom);
    b.resp = {$urandom, $urandom};
    return b;
  endfunction

  function automatic beat_t ctrl(act_kind_t what, int arg);
    beat_t b;
    b = '0;
    b.what = what;
    b.cfg_value = arg[0];
    b.pace = arg[6:0];
    return b;
  endfunction

  always @(posedge clk) begin : driver
    beat_t nxt;
    logic taken_now;
    logic go;
    logic wr_cfg;
    logic quiet;
    if (!rst) begin
      taken_now = start && !busy;
      go = start && busy;
      wr_cfg = 1'b0;
      quiet = !taken_now && !start && issued == got;
      if (taken_now) begin
        due_results.insert(due_results.size(), queue_step(cur_beat));
        issued <= issued + 1;
      end
      if (!go && pending.size() != 0) begin
        case (pending[0].what)
          ACT_PACE: begin
            nxt = take_pending();
            idle_pct = int'(nxt.pace);
          end
          ACT_DRAIN: begin
            if (quiet) begin
              nxt = take_pending();
            end
          end
          ACT_CFG: begin
            if (quiet) begin
              nxt = take_pending();
              wr_cfg = 1'b1;
              pmp_on = nxt.cfg_value;
              cfg_data <= nxt.cfg_value;
            end
          end
          default: begin
            if ($urandom_range(99) >= idle_pct) begin
              nxt = take_pending();
              cur_beat = nxt;
              go = 1'b1;
              func <= nxt.op;
              endpoint <= nxt.ep;
              activity <= nxt.act;
              phys_addr <= nxt.phys;
              is_write <= nxt.wr;
              fault_code <= nxt.fault;
              target_id <= nxt.tid;
              resp_word <= nxt.resp;
            end
          end
        endcase
      end
      start <= go;
      cfg_write <= wr_cfg;
    end
  end

  always @(posedge clk) begin : monitor
    outcome_t want;
    if (!rst && result_strobe) begin
      if (got == issued) begin
        report_mismatch("result beat with nothing outstanding", 64'(status), 64'(0));
      end else begin
        want = due_results[0];
        due_results.delete(0);
        got <= got + 1;
        check_field("req_kind", 64'(req_kind), 64'(want.kind));
        check_field("req_endpoint", 64'(req_endpoint), 64'(want.ep));
        check_field("req_activity", 64'(req_activity), 64'(want.act));
        check_field("req_phys", 64'(req_phys), 64'(want.phys));
        check_field("req_write", 64'(req_write), 64'(want.wr));
        check_field("req_fault", 64'(req_fault), 64'(want.fault));
        check_field("irq_pulse", 64'(irq_pulse), 64'(want.irq));
        check_field("new_id", 64'(new_id), 64'(want.nid));
        check_field("done_valid", 64'(done_valid), 64'(want.dvalid));
        check_field("done_id", 64'(done_id), 64'(want.did));
        check_field("done_resp", done_resp, want.dresp);
        check_field("status", 64'(status), 64'(want.status));
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || result_strobe || cfg_write) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("core_request_queue_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    beat_t b;
    func_t op;
    int pace_list [PHASES];
    int fill_list [PHASES];
    int ph;
    int n;
    int r;
    pace_list = '{0, 51, 13, 51, 0, 13};
    fill_list = '{70, 45, 30, 60, 40, 50};

    add_pending(ctrl(ACT_PACE, 0));
    add_pending(rand_beat(FUNC_COMPLETE));
    b = rand_beat(FUNC_ABORT);
    b.tid = 3'd5;
    add_pending(b);
    add_pending(rand_beat(FUNC_PMP));
    b = rand_beat(FUNC_FOREIGN);
    b.ep = '1;
    b.act = '0;
    add_pending(b);
    b = rand_beat(FUNC_FOREIGN);
    b.ep = '0;
    b.act = '1;
    add_pending(b);
    add_pending(ctrl(ACT_CFG, 1));
    b = rand_beat(FUNC_PMP);
    b.phys = '1;
    b.wr = 1'b1;
    b.fault = '1;
    add_pending(b);
    b = rand_beat(FUNC_PMP);
    b.phys = '0;
    b.wr = 1'b0;
    b.fault = '0;
    add_pending(b);
    // Four more fill the queue; the next two beats find it full.
    repeat (5) add_pending(rand_beat(FUNC_FOREIGN));
    add_pending(rand_beat(FUNC_PMP));
    b = rand_beat(FUNC_ABORT);
    b.tid = 3'd0;
    add_pending(b);
    b.tid = 3'd3;
    add_pending(b);
    b.tid = 3'd0;
    add_pending(b);
    add_pending(rand_beat(FUNC_FOREIGN));
    b = rand_beat(FUNC_COMPLETE);
    b.resp = '1;
    add_pending(b);
    b.resp = '0;
    add_pending(b);
    add_pending(rand_beat(FUNC_COMPLETE));
    add_pending(ctrl(ACT_CFG, 0));
    add_pending(rand_beat(FUNC_PMP));

    for (ph = 0; ph < PHASES; ph++) begin
      add_pending(ctrl(ACT_CFG, (ph % 2 == 0) ? 1 : 0));
      add_pending(ctrl(ACT_PACE, pace_list[ph]));
      for (n = 0; n < PHASE_BEATS; n++) begin
        r = int'($urandom_range(99));
        if (r < fill_list[ph]) begin
          op = $urandom_range(1) ? FUNC_PMP : FUNC_FOREIGN;
        end else if (r < fill_list[ph] + (100 - fill_list[ph]) / 2) begin
          op = FUNC_COMPLETE;
        end else begin
          op = FUNC_ABORT;
        end
        b = rand_beat(op);
        if ($urandom_range(15) == 0) begin
          b.ep = $urandom_range(1) ? '1 : '0;
          b.act = $urandom_range(1) ? '1 : '0;
          b.phys = $urandom_range(1) ? '1 : '0;
          b.fault = $urandom_range(1) ? '1 : '0;
          b.resp = $urandom_range(1) ? '1 : '0;
        end
        add_pending(b);
        if ($urandom_range(49) == 0) begin
          add_pending(ctrl(ACT_DRAIN, 0));
        end
      end
      add_pending(ctrl(ACT_DRAIN, 0));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start || issued != got) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      report_mismatch("result beats never seen", 64'(due_results.size()), 64'(0));
    end
    if (fails == 0) begin
      $display("core_request_queue_tb OK");
    end else begin
      $display("core_request_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/crq_pkg.sv
hdl/crq_ctrl.sv
hdl/crq_datapath.sv
hdl/core_request_queue.sv
hdl/crq_checker.sv
verif/core_request_queue_tb.sv
